/* rtl/jsu_pkg.sv */
// ----------------------------------------------------------------------------
// JSON string unescape package
// Result codes, error codes, register indexes and the result record used by
// the decoder; its checker shares the result kinds and error codes.
// ----------------------------------------------------------------------------
package jsu_pkg;

    // Kind of one result transaction.
    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_END   = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    // Error codes carried with an error result.
    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_NO_QUOTE   = 3'd1;
    localparam logic [2:0] ERR_BAD_ESCAPE = 3'd2;
    localparam logic [2:0] ERR_BAD_HEX    = 3'd3;
    localparam logic [2:0] ERR_CODE_RANGE = 3'd4;
    localparam logic [2:0] ERR_NON_ASCII  = 3'd5;

    // Output modes; the remaining codes behave as strict ASCII.
    localparam logic [1:0] MODE_UTF8  = 2'd0;
    localparam logic [1:0] MODE_SUBST = 2'd1;

    // Register indexes, taken from address bit 2.
    localparam logic REG_OUTPUT_MODE = 1'b0;
    localparam logic REG_SUBST_CHAR  = 1'b1;

    // One stored result.
    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic [2:0] err;
    } result_t;

endpackage

/* rtl/json_string_unescape_utf8.sv */
// ----------------------------------------------------------------------------
// JSON string unescape to UTF-8
// Byte-serial decoder of quoted JSON strings with escape and \u handling.
// ----------------------------------------------------------------------------
// The decoder takes one byte of JSON text per cycle, unless stalled, into an
// input register. When the result buffer can take them, the byte's results
// are loaded into a three-entry result buffer, which drives the result port
// and drains one result per cycle unless stalled. A byte that yields at most
// one result (plain bytes, simple escapes, quotes, errors, and \u values in
// the ASCII modes) is taken every cycle while the receiver does not stall. A
// \u value encoded as two or three UTF-8 bytes holds the result buffer until
// all its bytes are drained, and the following byte waits in the input
// register meanwhile, stalling the input. A stall on the result channel stalls
// the input in the same cycle once the input register is occupied. The user
// writes configuration over the APB port at byte addresses 0 (output_mode) and
// 4 (substitute_char) only while the block is idle, which it does not enforce.
module json_string_unescape_utf8
    import jsu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Input byte channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_byte,
    // Result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [7:0]  out_byte,
    output logic        last_of_run,
    output logic [2:0]  error_code,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_STR  = 2'd1,
        PH_ESC  = 2'd2,
        PH_HEX  = 2'd3
    } phase_t;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_U      = 8'h75;

    // Registers
    logic        in_vld_reg;
    logic [7:0]  in_byte_reg;
    phase_t      phase_reg,   phase_next;
    logic [1:0]  hex_cnt_reg, hex_cnt_next;
    logic [15:0] acc_reg,     acc_next;
    logic [1:0]  mode_reg;
    logic [7:0]  subst_reg;
    result_t     res_reg [3];
    result_t     res_next [3];
    logic [1:0]  res_n_reg,   res_n_next;
    logic [1:0]  res_idx_reg;

    // Decode scratch
    logic        do_emit;
    logic [15:0] val;
    logic        raw;
    logic        err_hit;
    logic [2:0]  err_code;
    logic        close_hit;
    logic        hex_ok;
    logic [7:0]  hex_diff;
    logic [3:0]  nib;

    // Handshake
    logic pop;
    logic last_pop;
    logic can_load;
    logic advance;
    logic accept;
    logic cfg_write;

    assign pop       = (res_n_reg != 2'd0) && !out_stall;
    assign last_pop  = pop && (res_idx_reg == (res_n_reg - 2'd1));
    assign can_load  = (res_n_reg == 2'd0) || last_pop;
    assign advance   = in_vld_reg && can_load;
    assign in_stall  = in_vld_reg && !can_load;
    assign accept    = in_valid && !in_stall;
    assign cfg_write = psel && penable && pwrite && pready;

    // Result port, driven from the head of the result buffer.
    assign out_valid   = (res_n_reg != 2'd0);
    assign kind        = res_reg[res_idx_reg].kind;
    assign out_byte    = res_reg[res_idx_reg].data;
    assign error_code  = res_reg[res_idx_reg].err;
    assign last_of_run = (res_idx_reg == (res_n_reg - 2'd1));

    // Configuration read-back.
    assign pready = 1'b1;
    always_comb
    begin
        if (paddr[2] == REG_SUBST_CHAR)
        begin
            prdata = {24'd0, subst_reg};
        end
        else
        begin
            prdata = {30'd0, mode_reg};
        end
    end

    // Hex digit recognition for the registered byte.
    always_comb
    begin
        hex_ok   = 1'b1;
        hex_diff = 8'd0;
        if (in_byte_reg inside {[8'h30:8'h39]})
        begin
            hex_diff = in_byte_reg - 8'h30;
        end
        else if (in_byte_reg inside {[8'h61:8'h66]})
        begin
            hex_diff = in_byte_reg - 8'h57;
        end
        else if (in_byte_reg inside {[8'h41:8'h46]})
        begin
            hex_diff = in_byte_reg - 8'h37;
        end
        else
        begin
            hex_ok = 1'b0;
        end
        nib = hex_diff[3:0];
    end

    // Next state and results for the byte held in the input register.
    always_comb
    begin
        phase_next   = phase_reg;
        hex_cnt_next = hex_cnt_reg;
        acc_next     = acc_reg;
        do_emit      = 1'b0;
        raw          = 1'b0;
        val          = 16'd0;
        err_hit      = 1'b0;
        err_code     = ERR_NONE;
        close_hit    = 1'b0;
        res_n_next   = 2'd0;
        for (int i = 0; i < 3; i++)
        begin
            res_next[i] = '{kind: KIND_DATA, data: 8'd0, err: ERR_NONE};
        end

        // Phase handling.
        case (phase_reg)
            PH_IDLE:
            begin
                if (in_byte_reg inside {CH_SPACE, CH_TAB, CH_LF, CH_CR})
                begin
                    phase_next = PH_IDLE;
                end
                else if (in_byte_reg == CH_QUOTE)
                begin
                    phase_next = PH_STR;
                end
                else
                begin
                    err_hit  = 1'b1;
                    err_code = ERR_NO_QUOTE;
                end
            end
            PH_STR:
            begin
                if (in_byte_reg == CH_QUOTE)
                begin
                    phase_next = PH_IDLE;
                    close_hit  = 1'b1;
                end
                else if (in_byte_reg == CH_BSLASH)
                begin
                    phase_next = PH_ESC;
                end
                else
                begin
                    do_emit = 1'b1;
                    raw     = 1'b1;
                    val     = {8'd0, in_byte_reg};
                end
            end
            PH_ESC:
            begin
                phase_next = PH_STR;
                do_emit    = 1'b1;
                case (in_byte_reg)
                    CH_T:      val = {8'd0, CH_TAB};
                    CH_N:      val = {8'd0, CH_LF};
                    CH_R:      val = {8'd0, CH_CR};
                    CH_F:      val = {8'd0, CH_FF};
                    CH_B:      val = {8'd0, CH_BS};
                    CH_SLASH:  val = {8'd0, CH_SLASH};
                    CH_BSLASH: val = {8'd0, CH_BSLASH};
                    CH_QUOTE:  val = {8'd0, CH_QUOTE};
                    CH_U:
                    begin
                        phase_next   = PH_HEX;
                        hex_cnt_next = 2'd0;
                        acc_next     = 16'd0;
                        do_emit      = 1'b0;
                    end
                    default:
                    begin
                        do_emit  = 1'b0;
                        err_hit  = 1'b1;
                        err_code = ERR_BAD_ESCAPE;
                    end
                endcase
            end
            PH_HEX:
            begin
                if (!hex_ok)
                begin
                    err_hit  = 1'b1;
                    err_code = ERR_BAD_HEX;
                end
                else if (hex_cnt_reg == 2'd3)
                begin
                    val          = {acc_reg[11:0], nib};
                    do_emit      = 1'b1;
                    phase_next   = PH_STR;
                    hex_cnt_next = 2'd0;
                    acc_next     = 16'd0;
                end
                else
                begin
                    acc_next     = {acc_reg[11:0], nib};
                    hex_cnt_next = hex_cnt_reg + 2'd1;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        // Encoding of a decoded value according to the output mode.
        if (do_emit)
        begin
            res_n_next = 2'd1;
            case (mode_reg)
                MODE_UTF8:
                begin
                    if (raw || (val <= 16'h007F))
                    begin
                        res_next[0].data = val[7:0];
                    end
                    else if (val <= 16'h07FF)
                    begin
                        res_n_next       = 2'd2;
                        res_next[0].data = {3'b110, val[10:6]};
                        res_next[1].data = {2'b10, val[5:0]};
                    end
                    else
                    begin
                        res_n_next       = 2'd3;
                        res_next[0].data = {4'b1110, val[15:12]};
                        res_next[1].data = {2'b10, val[11:6]};
                        res_next[2].data = {2'b10, val[5:0]};
                    end
                end
                MODE_SUBST:
                begin
                    if ((val < 16'd32) || (val >= 16'd127))
                    begin
                        res_next[0].data = subst_reg;
                    end
                    else
                    begin
                        res_next[0].data = val[7:0];
                    end
                end
                default:
                begin
                    if (val > 16'd255)
                    begin
                        err_hit  = 1'b1;
                        err_code = ERR_CODE_RANGE;
                    end
                    else if (val >= 16'd127)
                    begin
                        err_hit  = 1'b1;
                        err_code = ERR_NON_ASCII;
                    end
                    else
                    begin
                        res_next[0].data = val[7:0];
                    end
                end
            endcase
        end

        // An error returns the decoder to idle with a single result.
        if (err_hit)
        begin
            phase_next   = PH_IDLE;
            hex_cnt_next = 2'd0;
            acc_next     = 16'd0;
            res_n_next   = 2'd1;
            res_next[0]  = '{kind: KIND_ERROR, data: 8'd0, err: err_code};
        end

        // A closing quote gives the end result.
        if (close_hit)
        begin
            res_n_next  = 2'd1;
            res_next[0] = '{kind: KIND_END, data: 8'd0, err: ERR_NONE};
        end
    end

    // State, input register, result buffer and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            in_byte_reg <= 8'd0;
            phase_reg   <= PH_IDLE;
            hex_cnt_reg <= 2'd0;
            acc_reg     <= 16'd0;
            mode_reg    <= MODE_UTF8;
            subst_reg   <= 8'd63;
            res_n_reg   <= 2'd0;
            res_idx_reg <= 2'd0;
            for (int i = 0; i < 3; i++)
            begin
                res_reg[i] <= '{kind: KIND_DATA, data: 8'd0, err: ERR_NONE};
            end
        end
        else
        begin
            // Input register.
            if (accept)
            begin
                in_vld_reg  <= 1'b1;
                in_byte_reg <= in_byte;
            end
            else if (advance)
            begin
                in_vld_reg <= 1'b0;
            end

            // Decode step and result buffer.
            if (advance)
            begin
                phase_reg   <= phase_next;
                hex_cnt_reg <= hex_cnt_next;
                acc_reg     <= acc_next;
                res_n_reg   <= res_n_next;
                res_idx_reg <= 2'd0;
                for (int i = 0; i < 3; i++)
                begin
                    res_reg[i] <= res_next[i];
                end
            end
            else if (pop)
            begin
                if (last_pop)
                begin
                    res_n_reg   <= 2'd0;
                    res_idx_reg <= 2'd0;
                end
                else
                begin
                    res_idx_reg <= res_idx_reg + 2'd1;
                end
            end

            // Configuration writes.
            if (cfg_write)
            begin
                if (paddr[2] == REG_OUTPUT_MODE)
                begin
                    mode_reg <= pwdata[1:0];
                end
                else
                begin
                    subst_reg <= pwdata[7:0];
                end
            end
        end
    end

endmodule

/* rtl/jsu_checker.sv */
// ----------------------------------------------------------------------------
// JSON string unescape checker
// Port-level properties of the decoder's input and result channels.
// ----------------------------------------------------------------------------
module jsu_checker
    import jsu_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [7:0]  in_byte,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  kind,
    input logic [7:0]  out_byte,
    input logic        last_of_run,
    input logic [2:0]  error_code
);

    // A stalled input transaction holds its byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(in_byte))
    else $error("stalled input byte changed");

    // A stalled result transaction holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(kind) && $stable(out_byte)
            && $stable(last_of_run) && $stable(error_code))
    else $error("stalled result changed");

    // An error is always the only result of its byte and carries a code.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_ERROR) |-> last_of_run && (error_code != ERR_NONE)
            && (out_byte == 8'd0))
    else $error("malformed error result");

    // Only error results carry an error code.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind != KIND_ERROR) |-> (error_code == ERR_NONE))
    else $error("error code on a non-error result");

    // A closing quote yields one end result with no data.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_END) |-> last_of_run && (out_byte == 8'd0))
    else $error("malformed end result");

endmodule

bind json_string_unescape_utf8 jsu_checker u_jsu_checker (.*);
